@@ src/dlr_pkg.sv @@
package dlr_pkg;

   // request kinds (req_tuser)
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_WIDTH       = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BYTES_PER_PIXEL = 1'b1;

   // fixed field widths
   localparam int ROW_WIDTH_BITS = 13;
   localparam int BPP_BITS       = 3;
   localparam int CSR_DATA_BITS  = 13;
   localparam int OFFSET_BITS    = 26;
   localparam int COLOR_BITS     = 32;

   // register reset values
   localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 13'd640;
   localparam logic [BPP_BITS-1:0]       BPP_RESET       = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic load_line;   // latch endpoints, spans and start the divider
      logic div_step;    // one quotient bit
      logic take_pixel;  // form pixel coordinates, advance the step
      logic calc_row;    // y * row_width + x
      logic load_out;    // scale by bytes per pixel into the output register
   } dlr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;    // last quotient bit in this cycle
      logic span_zero;   // latched line has no pixels
      logic pixel_last;  // current step is the final pixel
   } dlr_status_type;

endpackage

@@ src/dlr_datapath.sv @@
module dlr_datapath #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dlr_pkg::dlr_cmd_type               cmd,
   output dlr_pkg::dlr_status_type            status,
   input  logic                               csr_write,
   input  logic [dlr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dlr_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic [COORD_BITS-1:0]              start_x,
   input  logic [COORD_BITS-1:0]              start_y,
   input  logic [COORD_BITS-1:0]              end_x,
   input  logic [COORD_BITS-1:0]              end_y,
   input  logic [dlr_pkg::COLOR_BITS-1:0]     line_color,
   output logic [COORD_BITS-1:0]              pixel_x,
   output logic [COORD_BITS-1:0]              pixel_y,
   output logic [dlr_pkg::OFFSET_BITS-1:0]    pixel_offset,
   output logic [dlr_pkg::COLOR_BITS-1:0]     pixel_color,
   output logic                               last_pixel
);
   import dlr_pkg::*;

   localparam int DIV_BITS = COORD_BITS + FRAC_BITS;
   localparam int CNT_BITS = $clog2(DIV_BITS);
   localparam int ACC_BITS = COORD_BITS + FRAC_BITS + 1;

   // configuration registers
   logic [ROW_WIDTH_BITS-1:0] row_width_ff, row_width_in;
   logic [BPP_BITS-1:0]       bpp_ff, bpp_in;

   // line state
   logic [COORD_BITS-1:0] origin_x_ff, origin_x_in;
   logic [COORD_BITS-1:0] origin_y_ff, origin_y_in;
   logic [COORD_BITS-1:0] span_ff, span_in;
   logic [COORD_BITS-1:0] step_ff, step_in;
   logic                  major_neg_ff, major_neg_in;
   logic                  minor_neg_ff, minor_neg_in;
   logic                  y_major_ff, y_major_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   // divider: quotient shifts in from the bottom as the dividend shifts out
   logic [DIV_BITS-1:0]   div_rq_ff, div_rq_in;
   logic [COORD_BITS-1:0] div_rem_ff, div_rem_in;
   logic [COORD_BITS-1:0] div_den_ff, div_den_in;
   logic [CNT_BITS-1:0]   div_cnt_ff, div_cnt_in;

   // pixel pipeline
   logic [COORD_BITS-1:0]  px_ff, px_in;
   logic [COORD_BITS-1:0]  py_ff, py_in;
   logic                   last_ff, last_in;
   logic [OFFSET_BITS-1:0] row_ff, row_in;

   // output register
   logic [COORD_BITS-1:0]  out_x_ff, out_y_ff;
   logic [OFFSET_BITS-1:0] out_off_ff, out_off_in;
   logic [COLOR_BITS-1:0]  out_color_ff;
   logic                   out_last_ff;

   // start decode
   logic [COORD_BITS:0]   dx, dy, dx_neg, dy_neg;
   logic [COORD_BITS-1:0] adx, ady;
   logic                  swap;

   // divider step
   logic [COORD_BITS:0] div_trial;
   logic                div_ge;

   // pixel coordinates
   logic [FRAC_BITS:0]    slope_mag;
   logic [COORD_BITS-1:0] minor_mag, origin_major, origin_minor;
   logic [COORD_BITS-1:0] major_coord, minor_coord;
   logic [COORD_BITS:0]   step_next;
   logic                  pixel_last;

   // spans, magnitudes and axis swap
   always_comb begin
      dx     = {1'b0, end_x} - {1'b0, start_x};
      dy     = {1'b0, end_y} - {1'b0, start_y};
      dx_neg = -dx;
      dy_neg = -dy;
      adx    = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
      ady    = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
      swap   = ady > adx;
   end

   // restoring division step
   always_comb begin
      div_trial = {div_rem_ff, div_rq_ff[DIV_BITS-1]};
      div_ge    = div_trial >= {1'b0, div_den_ff};
   end

   // pixel coordinates from the current step
   always_comb begin
      slope_mag    = div_rq_ff[FRAC_BITS:0];
      minor_mag    = acc_ff[FRAC_BITS +: COORD_BITS];
      origin_major = y_major_ff ? origin_y_ff : origin_x_ff;
      origin_minor = y_major_ff ? origin_x_ff : origin_y_ff;
      major_coord  = major_neg_ff ? origin_major - step_ff : origin_major + step_ff;
      minor_coord  = minor_neg_ff ? origin_minor - minor_mag : origin_minor + minor_mag;
      step_next    = {1'b0, step_ff} + 1'b1;
      pixel_last   = step_next >= {1'b0, span_ff};
   end

   // next-state values
   always_comb begin
      row_width_in = row_width_ff;
      bpp_in       = bpp_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ROW_WIDTH:       row_width_in = csr_data[ROW_WIDTH_BITS-1:0];
            REG_BYTES_PER_PIXEL: bpp_in       = csr_data[BPP_BITS-1:0];
            default: ;
         endcase
      end

      origin_x_in  = origin_x_ff;
      origin_y_in  = origin_y_ff;
      span_in      = span_ff;
      step_in      = step_ff;
      major_neg_in = major_neg_ff;
      minor_neg_in = minor_neg_ff;
      y_major_in   = y_major_ff;
      acc_in       = acc_ff;
      color_in     = color_ff;
      div_rq_in    = div_rq_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_cnt_in   = div_cnt_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      last_in      = last_ff;

      if (cmd.load_line) begin
         origin_x_in  = start_x;
         origin_y_in  = start_y;
         color_in     = line_color;
         y_major_in   = swap;
         major_neg_in = swap ? dy[COORD_BITS] : dx[COORD_BITS];
         minor_neg_in = swap ? dx[COORD_BITS] : dy[COORD_BITS];
         span_in      = swap ? ady : adx;
         step_in      = '0;
         acc_in       = '0;
         div_rq_in    = {(swap ? adx : ady), {FRAC_BITS{1'b0}}};
         div_rem_in   = '0;
         div_den_in   = swap ? ady : adx;
         div_cnt_in   = '0;
      end

      if (cmd.div_step) begin
         div_rem_in = div_ge ? COORD_BITS'(div_trial - {1'b0, div_den_ff})
                             : div_trial[COORD_BITS-1:0];
         div_rq_in  = {div_rq_ff[DIV_BITS-2:0], div_ge};
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      if (cmd.take_pixel) begin
         px_in   = y_major_ff ? minor_coord : major_coord;
         py_in   = y_major_ff ? major_coord : minor_coord;
         last_in = pixel_last;
         if (!pixel_last) begin
            step_in = step_next[COORD_BITS-1:0];
            acc_in  = acc_ff + ACC_BITS'(slope_mag);
         end
      end
   end

   // offset arithmetic, modulo the offset width
   always_comb begin
      row_in     = OFFSET_BITS'(OFFSET_BITS'(py_ff) * OFFSET_BITS'(row_width_ff))
                 + OFFSET_BITS'(px_ff);
      out_off_in = OFFSET_BITS'(row_ff * OFFSET_BITS'(bpp_ff));
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         bpp_ff       <= BPP_RESET;
      end else begin
         row_width_ff <= row_width_in;
         bpp_ff       <= bpp_in;
      end
   end

   // line state, divider and pixel pipeline
   always_ff @(posedge clock) begin
      origin_x_ff  <= origin_x_in;
      origin_y_ff  <= origin_y_in;
      span_ff      <= span_in;
      step_ff      <= step_in;
      major_neg_ff <= major_neg_in;
      minor_neg_ff <= minor_neg_in;
      y_major_ff   <= y_major_in;
      acc_ff       <= acc_in;
      color_ff     <= color_in;
      div_rq_ff    <= div_rq_in;
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      div_cnt_ff   <= div_cnt_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      last_ff      <= last_in;
      if (cmd.calc_row) begin
         row_ff <= row_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_x_ff     <= px_ff;
         out_y_ff     <= py_ff;
         out_off_ff   <= out_off_in;
         out_color_ff <= color_ff;
         out_last_ff  <= last_ff;
      end
   end

   assign status.div_done   = div_cnt_ff == CNT_BITS'(DIV_BITS - 1);
   assign status.span_zero  = span_ff == '0;
   assign status.pixel_last = pixel_last;

   assign pixel_x      = out_x_ff;
   assign pixel_y      = out_y_ff;
   assign pixel_offset = out_off_ff;
   assign pixel_color  = out_color_ff;
   assign last_pixel   = out_last_ff;

endmodule

@@ src/dlr_ctrl.sv @@
module dlr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_kind,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  dlr_pkg::dlr_status_type status,
   output dlr_pkg::dlr_cmd_type    cmd
);
   import dlr_pkg::*;

   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_DIV    = 2'd1;
   localparam logic [1:0] ST_MUL    = 2'd2;
   localparam logic [1:0] ST_SCALE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       line_active_ff, line_active_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_fire, out_free;

   assign req_tready = state_ff == ST_ACCEPT;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      line_active_in = line_active_ff;
      cmd            = '0;
      unique case (state_ff)
         ST_ACCEPT: begin
            if (req_fire) begin
               if (req_kind == KIND_START) begin
                  cmd.load_line  = 1'b1;
                  line_active_in = 1'b0;
                  state_in       = ST_DIV;
               end else if (line_active_ff) begin
                  cmd.take_pixel = 1'b1;
                  if (status.pixel_last) begin
                     line_active_in = 1'b0;
                  end
                  state_in = ST_MUL;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               line_active_in = !status.span_zero;
               state_in       = ST_ACCEPT;
            end
         end
         ST_MUL: begin
            cmd.calc_row = 1'b1;
            state_in     = ST_SCALE;
         end
         ST_SCALE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   // result valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_ACCEPT;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // no line is live while the slope is being divided
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> !line_active_ff)
      else $error("line active during slope division");

   // a pixel is only formed for a live line
   assert property (@(posedge clock) disable iff (reset)
      cmd.take_pixel |-> line_active_ff)
      else $error("pixel taken with no active line");

   // the final pixel ends the line
   assert property (@(posedge clock) disable iff (reset)
      cmd.take_pixel && status.pixel_last |=> !line_active_ff)
      else $error("line still active after final pixel");

   // a finished pixel lands in the output register and the block reopens
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCALE && out_free |=> rsp_valid_ff && state_ff == ST_ACCEPT)
      else $error("pixel result not presented");

endmodule

@@ src/dda_line_rasterizer.sv @@
// DDA line rasterizer. A start request (req_tuser = 0) latches both endpoints
// and the color, swaps axes when the y span is longer, and divides the short
// span by the long span into an unsigned Q(FRAC_BITS) slope magnitude with a
// restoring divider that makes one quotient bit per cycle; the block takes no
// further request until the last quotient bit is made. Each step request
// (req_tuser = 1) then yields one pixel: x, y, byte offset (x + y *
// row_width) * bytes_per_pixel modulo 2^26, the color and tlast on the final
// pixel. A step passes coordinate forming, the row multiply and the byte
// scaling in turn; no new request is taken until the scaling has loaded the
// output register, which waits until an earlier result has been taken; a
// waiting result sits in the output register while the next request is
// accepted. The end point is not drawn, a zero-length line gives no pixels
// and steps while idle are dropped. There is no clipping. Write row_width
// (index 0) and bytes_per_pixel (index 1) only while the block is idle.
module dda_line_rasterizer #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // start_x, start_y, end_x, end_y, line_color
   input  logic [((4*COORD_BITS+dlr_pkg::COLOR_BITS+7)/8)*8-1:0] req_tdata,
   // kind
   input  logic                               req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pixel_x, pixel_y, pixel_offset, pixel_color
   output logic [((2*COORD_BITS+dlr_pkg::OFFSET_BITS+dlr_pkg::COLOR_BITS+7)/8)*8-1:0]
                                              rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_write,
   input  logic [dlr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dlr_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import dlr_pkg::*;

   localparam int RSP_DATA_BITS = ((2*COORD_BITS+OFFSET_BITS+COLOR_BITS+7)/8)*8;

   dlr_cmd_type    cmd;
   dlr_status_type status;

   logic [COORD_BITS-1:0]  pixel_x, pixel_y;
   logic [OFFSET_BITS-1:0] pixel_offset;
   logic [COLOR_BITS-1:0]  pixel_color;

   dlr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dlr_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .start_x      (req_tdata[0 +: COORD_BITS]),
      .start_y      (req_tdata[COORD_BITS +: COORD_BITS]),
      .end_x        (req_tdata[2*COORD_BITS +: COORD_BITS]),
      .end_y        (req_tdata[3*COORD_BITS +: COORD_BITS]),
      .line_color   (req_tdata[4*COORD_BITS +: COLOR_BITS]),
      .pixel_x      (pixel_x),
      .pixel_y      (pixel_y),
      .pixel_offset (pixel_offset),
      .pixel_color  (pixel_color),
      .last_pixel   (rsp_tlast)
   );

   // pack result fields, lowest first, zero filled to whole bytes
   assign rsp_tdata = RSP_DATA_BITS'({pixel_color, pixel_offset, pixel_y, pixel_x});

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import dlr_pkg::*;

   localparam int REQ_BITS = 80;   // 4 x 12-bit coordinates + 32-bit color
   localparam int RSP_BITS = 88;   // 12 + 12 + 26 + 32 = 82, padded to bytes

   // Predicts the pixel stream of the rasterizer and holds the pixels still owed.
   class raster_scoreboard;
      localparam int FRAC = 16;

      typedef struct {
         logic [11:0] x;
         logic [11:0] y;
         logic [25:0] offset;
         logic [31:0] color;
         bit          last;
      } pixel_rec_type;

      logic [12:0]        row_width;
      logic [2:0]         bytes_per_pixel;
      logic [11:0]        org_x;
      logic [11:0]        org_y;
      logic [12:0]        span;
      logic [12:0]        step_idx;
      bit                 step_neg;
      bit                 y_major;
      bit                 drawing;
      logic signed [17:0] slope_q16;
      logic signed [29:0] minor_acc;
      logic [31:0]        held_color;
      pixel_rec_type      expected_pixels[$];

      function new();
         row_width       = ROW_WIDTH_RESET;
         bytes_per_pixel = BPP_RESET;
         org_x = '0;
         org_y = '0;
         span = '0;
         step_idx = '0;
         step_neg = 0;
         y_major = 0;
         drawing = 0;
         slope_q16 = '0;
         minor_acc = '0;
         held_color = '0;
      endfunction

      function int magnitude(int v);
         return (v < 0) ? -v : v;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] value);
         if (index == REG_ROW_WIDTH)
            row_width = value[12:0];
         else if (index == REG_BYTES_PER_PIXEL)
            bytes_per_pixel = value[2:0];
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // Apply one accepted request; a step on an active line owes one pixel.
      function void note_request(logic kind, logic [11:0] sx, logic [11:0] sy,
                                 logic [11:0] ex, logic [11:0] ey, logic [31:0] color);
         int            d_minor;
         int            d_major;
         int            t;
         longint        mag;
         longint        s;
         longint        k;
         longint        major_off;
         longint        minor_off;
         longint        px;
         longint        py;
         longint        off;
         bit            last;
         pixel_rec_type p;
         if (kind == KIND_START) begin
            d_minor = int'(ey) - int'(sy);
            d_major = int'(ex) - int'(sx);
            y_major = 0;
            if (magnitude(d_minor) > magnitude(d_major)) begin
               t = d_minor;
               d_minor = d_major;
               d_major = t;
               y_major = 1;
            end
            org_x = sx;
            org_y = sy;
            held_color = color;
            step_neg = d_major < 0;
            span = 13'(magnitude(d_major));
            step_idx = '0;
            minor_acc = '0;
            if (span != 0) begin
               mag = (longint'(magnitude(d_minor)) << FRAC) / longint'(span);
               s = ((d_minor < 0) != (d_major < 0)) ? -mag : mag;
               slope_q16 = s[17:0];
            end else begin
               slope_q16 = '0;
            end
            drawing = span != 0;
            return;
         end
         if (!drawing)
            return;

         k = longint'(step_idx);
         major_off = step_neg ? -k : k;
         minor_off = longint'(minor_acc) / (longint'(1) << FRAC);  // truncates toward zero
         last = (int'(step_idx) + 1) >= int'(span);
         if (y_major) begin
            px = (longint'(org_x) + minor_off) & 64'hFFF;
            py = (longint'(org_y) + major_off) & 64'hFFF;
         end else begin
            px = (longint'(org_x) + major_off) & 64'hFFF;
            py = (longint'(org_y) + minor_off) & 64'hFFF;
         end
         off = ((px + py * longint'(row_width)) * longint'(bytes_per_pixel)) & 64'h3FF_FFFF;
         p.x = px[11:0];
         p.y = py[11:0];
         p.offset = off[25:0];
         p.color = held_color;
         p.last = last;
         expected_pixels.push_back(p);

         if (last) begin
            drawing = 0;
         end else begin
            step_idx = step_idx + 13'd1;
            minor_acc = minor_acc + (step_neg ? -slope_q16 : slope_q16);
         end
      endfunction

      // Compare one delivered pixel with the oldest one owed; why lists the bad fields.
      function bit check_pixel(logic [11:0] x, logic [11:0] y, logic [25:0] offset,
                               logic [31:0] color, logic last, output string why);
         pixel_rec_type e;
         why = "";
         if (expected_pixels.size() == 0) begin
            why = $sformatf(" unexpected pixel x=%0d y=%0d", x, y);
            return 0;
         end
         e = expected_pixels.pop_front();
         if (x !== e.x)
            why = {why, $sformatf(" x got %0d exp %0d", x, e.x)};
         if (y !== e.y)
            why = {why, $sformatf(" y got %0d exp %0d", y, e.y)};
         if (offset !== e.offset)
            why = {why, $sformatf(" offset got %0d exp %0d", offset, e.offset)};
         if (color !== e.color)
            why = {why, $sformatf(" color got %h exp %h", color, e.color)};
         if (last !== e.last)
            why = {why, $sformatf(" last got %b exp %b", last, e.last)};
         return why == "";
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic [REQ_BITS-1:0]       req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [RSP_BITS-1:0]       rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   raster_scoreboard sb;
   int  errors = 0;
   bit  sender_burst = 0;
   bit  receiver_burst = 0;
   bit  rsp_hold_req = 0;

   dda_line_rasterizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),   // start_x, start_y, end_x, end_y, line_color
      .req_tuser  (req_tuser),   // kind
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),   // pixel_x, pixel_y, pixel_offset, pixel_color
      .rsp_tlast  (rsp_tlast),   // last_pixel
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string why);
      errors++;
      $display("%0t ns pixel mismatch:%s", $time, why);
   endtask

   // Result side: random back-pressure, with one long hold-off on demand.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_burst ? 0 : $urandom_range(0, 14);
         if (rsp_hold_req) begin
            stall = 400;
            rsp_hold_req = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Check every accepted pixel.
   always @(posedge clock) begin
      string why;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (!sb.check_pixel(rsp_tdata[11:0], rsp_tdata[23:12], rsp_tdata[49:24],
                             rsp_tdata[81:50], rsp_tlast, why))
            report_mismatch(why);
      end
   end

   // One request: random gap, then hold valid until accepted.
   task automatic send_request(input logic kind, input logic [11:0] sx, input logic [11:0] sy,
                               input logic [11:0] ex, input logic [11:0] ey,
                               input logic [31:0] color);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {color, ey, ex, sy, sx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, sx, sy, ex, ey, color);
   endtask

   // Step request; the endpoint fields carry junk the block must ignore.
   task automatic send_step();
      send_request(KIND_STEP, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), $urandom);
   endtask

   task automatic send_line(input logic [11:0] sx, input logic [11:0] sy,
                            input logic [11:0] ex, input logic [11:0] ey,
                            input logic [31:0] color, input int steps);
      send_request(KIND_START, sx, sy, ex, ey, color);
      repeat (steps) send_step();
   endtask

   // Stop offering and wait until every owed pixel has come back.
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // New register setting; a start may still be in the divider, so let it settle.
   task automatic change_setting(input logic [12:0] rw, input logic [2:0] bpp);
      logic [CSR_DATA_BITS-1:0] bpp_word;
      drain_pixels();
      repeat (40) @(posedge clock);
      bpp_word = {10'($urandom_range(0, 1023)), bpp};
      csr_write <= 1'b1;
      csr_index <= REG_ROW_WIDTH;
      csr_data  <= rw;
      @(posedge clock);
      sb.set_reg(REG_ROW_WIDTH, rw);
      csr_index <= REG_BYTES_PER_PIXEL;
      csr_data  <= bpp_word;
      @(posedge clock);
      sb.set_reg(REG_BYTES_PER_PIXEL, bpp_word);
      csr_write <= 1'b0;
   endtask

   function automatic int clamp_coord(int v);
      if (v < 0)
         return 0;
      if (v > 4095)
         return 4095;
      return v;
   endfunction

   // Mostly short complete lines with random content; some long aborted
   // lines, zero-length lines, overrun steps and stray steps.
   task automatic random_lines(input int target);
      int made;
      int r;
      int sx;
      int sy;
      int ex;
      int ey;
      int reach;
      int span;
      int nsteps;
      int q;
      int i;
      made = 0;
      while (made < target) begin
         if ($urandom_range(0, 19) == 0)
            send_step();
         r  = $urandom_range(0, 99);
         sx = $urandom_range(0, 4095);
         sy = $urandom_range(0, 4095);
         if (r < 8) begin
            ex = sx;
            ey = sy;
         end else if (r < 16) begin
            ex = $urandom_range(0, 4095);
            ey = $urandom_range(0, 4095);
         end else begin
            reach = ($urandom_range(0, 3) == 0) ? 40 : 10;
            ex = clamp_coord(sx + $urandom_range(0, 2 * reach) - reach);
            ey = clamp_coord(sy + $urandom_range(0, 2 * reach) - reach);
         end
         span = (ex > sx) ? ex - sx : sx - ex;
         if (((ey > sy) ? ey - sy : sy - ey) > span)
            span = (ey > sy) ? ey - sy : sy - ey;
         if (r < 8) begin
            nsteps = 1;
         end else if (r < 16) begin
            nsteps = $urandom_range(1, 8);
            if (nsteps > span)
               nsteps = span;
         end else begin
            q = $urandom_range(0, 9);
            nsteps = (q == 0) ? span / 2 : (q == 1) ? span + 2 : span;
         end
         send_request(KIND_START, 12'(sx), 12'(sy), 12'(ex), 12'(ey), $urandom);
         made++;
         for (i = 0; i < nsteps; i++) begin
            send_step();
            if (i < span)
               made++;
         end
      end
   endtask

   // Main sequence
   initial begin
      logic [12:0] rw_set[6];
      logic [2:0]  bpp_set[6];
      int          ph;
      int          n;
      sb = new();
      rw_set  = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd1000, 13'd0};
      bpp_set = '{3'd4, 3'd1, 3'd7, 3'd0, 3'd2, 3'd0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset register values
      send_step();                                                  // idle step
      send_line(12'd0, 12'd0, 12'd0, 12'd0, 32'h0000_0000, 1);        // zero-length line
      send_line(12'd4095, 12'd4095, 12'd4092, 12'd4090, 32'hFFFF_FFFF, 5); // steep, both negative
      send_line(12'd0, 12'd0, 12'd3, 12'd1, 32'hA5A5_5A5A, 3);        // shallow, positive
      send_line(12'd0, 12'd4095, 12'd2, 12'd4093, 32'h0123_4567, 2);  // diagonal, no swap
      send_line(12'd10, 12'd10, 12'd20, 12'd30, 32'h89AB_CDEF, 2);    // aborted by next start
      send_line(12'd4095, 12'd0, 12'd4094, 12'd0, 32'h5555_AAAA, 2);  // one pixel, then idle step

      for (ph = 0; ph < 6; ph++) begin
         if (ph == 5)
            change_setting(13'($urandom_range(1, 4096)), 3'($urandom_range(1, 4)));
         else
            change_setting(rw_set[ph], bpp_set[ph]);
         sender_burst   = (ph == 2) || ($urandom_range(0, 3) == 0);
         receiver_burst = (ph == 2) || ($urandom_range(0, 3) == 0);
         if (ph == 1) begin
            // long result hold-off while requests keep coming
            sender_burst = 1;
            rsp_hold_req = 1;
            send_line(12'd100, 12'd100, 12'd130, 12'd110, $urandom, 30);
            sender_burst = 0;
         end
         random_lines(75);
         if (ph == 3)
            drain_pixels();
         random_lines(75);
      end

      // wind down
      drain_pixels();
      for (n = 0; n < 5000 && sb.pending() != 0; n++) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.pending() != 0)
         report_mismatch($sformatf(" %0d pixels never delivered", sb.pending()));
      if (errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
